/* hdl/aopa_pkg.sv */
// Shared types and constants for the antithetic option payoff accumulator.
package aopa_pkg;

  localparam int SUM_WIDTH_DEF   = 64;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int DIV_DW = 64;
  localparam int DIV_SW = 32;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SPOT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIKE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PUT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIFT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT  = 3'd5;

  localparam logic [31:0] SPOT_RST      = 32'd6553600;
  localparam logic [31:0] STRIKE_RST    = 32'd6553600;
  localparam logic [31:0] DRIFT_RST     = 32'd0;
  localparam logic [30:0] DIFFUSION_RST = 31'd3355443;
  localparam logic [31:0] DISCOUNT_RST  = 32'hFFFF_FFFF;

  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  // floor(2^63 / LN2_Q32): quotient estimate for the range reduction
  localparam logic [31:0] LN2_RECIP    = 32'(64'h8000_0000_0000_0000 / 64'd2977044472);
  localparam logic [4:0]  TAYLOR_TERMS = 5'd16;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MUL_M, OP_SET_M, OP_MUL_N, OP_SET_QA, OP_MUL_NL,
    OP_SET_NR, OP_MUL_T, OP_TERM, OP_MUL_P, OP_PRICE, OP_NEXT_PATH,
    OP_OPT_ZERO, OP_START_Q, OP_SET_Q, OP_MUL_Q, OP_MUL_R, OP_START_R,
    OP_FINAL, OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic pair;
    logic fin;
    logic path;
    logic k_last;
    logic count_zero;
  } dp_status_t;

endpackage

/* hdl/aopa_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
module aopa_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [aopa_pkg::DIV_DW-1:0] dividend,
  input  logic [aopa_pkg::DIV_SW-1:0] divisor,
  output logic                      done,
  output logic [aopa_pkg::DIV_DW-1:0] quotient,
  output logic [aopa_pkg::DIV_SW-1:0] remainder
);
  import aopa_pkg::*;

  localparam int CW = $clog2(DIV_DW);
  localparam logic [CW-1:0] CNT_LAST = CW'(DIV_DW - 1);

  logic [DIV_DW-1:0] quo_r;
  logic [DIV_SW-1:0] rem_r;
  logic [DIV_SW-1:0] dsr_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DIV_SW:0]   trial;
  logic              ge;
  logic [DIV_SW:0]   diff;

  always_comb begin
    trial = {rem_r, quo_r[DIV_DW-1]};
    ge    = trial >= {1'b0, dsr_r};
    diff  = trial - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      quo_r  <= dividend;
      rem_r  <= '0;
      dsr_r  <= divisor;
      cnt_r  <= '0;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_DW-2:0], ge};
      rem_r <= ge ? diff[DIV_SW-1:0] : trial[DIV_SW-1:0];
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* hdl/aopa_datapath.sv */
// Datapath: configuration, multiplier, divider, exponential and accumulators.
module aopa_datapath #(
  parameter int SUM_WIDTH   = aopa_pkg::SUM_WIDTH_DEF,
  parameter int COUNT_WIDTH = aopa_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [aopa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata,
  input  logic [31:0]                   in_tdata,
  input  logic                          in_tuser,
  input  logic                          in_tlast,
  input  aopa_pkg::ctrl_cmd_t           cmd,
  output aopa_pkg::dp_status_t          status,
  output logic [31:0]                   out_tdata,
  output logic                          out_tuser,
  output logic                          out_tlast
);
  import aopa_pkg::*;

  localparam logic [63:0] P34 = 64'd1 << 34;
  localparam logic [63:0] P35 = 64'd1 << 35;
  localparam logic [63:0] P36 = 64'd1 << 36;

  // configuration
  logic [31:0] spot_r, strike_r, drift_r, disc_r;
  logic [30:0] diff_r;
  logic        put_r;

  // item and path state
  logic [31:0] z_r;
  logic        pair_r, fin_r, path_r;
  logic [63:0] prod_r;
  logic [35:0] m_r;
  logic        xneg_r;
  logic [6:0]  qa_r;
  logic signed [7:0] n_r;
  logic [31:0] r_r;
  logic [32:0] term_r;
  logic [33:0] tsum_r;
  logic [4:0]  k_r;
  logic [31:0] q_r, rem_r;
  logic [63:0] t_r;

  logic [SUM_WIDTH-1:0]   sum_r;
  logic [COUNT_WIDTH-1:0] count_r;

  logic [31:0] val_r;
  logic        kind_r, last_r;

  // divider
  logic              div_start;
  logic [DIV_DW-1:0] div_dvd;
  logic [DIV_SW-1:0] div_dsr;
  logic              div_done;
  logic [DIV_DW-1:0] div_quo;
  logic [DIV_SW-1:0] div_rem;

  aopa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // exponent argument and range reduction
  logic        z_neg;
  logic [31:0] zmag;
  logic        tneg;
  logic signed [37:0] xs;
  logic signed [30:0] xc;
  logic [29:0] xmag;
  logic [37:0] x32mag;
  logic [38:0] red_full;
  logic        red_hi;
  logic [31:0] red_rem;
  logic [6:0]  qa;
  logic signed [7:0] n_nxt;
  logic [31:0] r_nxt;

  always_comb begin
    z_neg  = z_r[31];
    zmag   = z_neg ? (32'd0 - z_r) : z_r;
    tneg   = z_neg ^ path_r;
    xs     = tneg ? ({{6{drift_r[31]}}, drift_r} - $signed({2'b00, m_r}))
                  : ({{6{drift_r[31]}}, drift_r} + $signed({2'b00, m_r}));
    if (xs > 38'sd536870912)       xc = 31'sd536870912;
    else if (xs < -38'sd536870912) xc = -31'sd536870912;
    else                           xc = xs[30:0];
    xmag   = xc[30] ? 30'(-xc) : xc[29:0];
    x32mag = {xmag, 8'd0};
    // estimate is exact or one low; one compare and subtract fixes it
    red_full = {1'b0, x32mag} - prod_r[38:0];
    red_hi   = (red_full[32:0] >= {1'b0, LN2_Q32});
    qa       = red_hi ? (qa_r + 7'd1) : qa_r;
    red_rem  = red_hi ? 32'(red_full[32:0] - {1'b0, LN2_Q32}) : red_full[31:0];
    r_nxt  = red_rem;
    n_nxt  = $signed({1'b0, qa});
    if (xneg_r) begin
      if (red_rem == 32'd0) begin
        n_nxt = -$signed({1'b0, qa});
      end else begin
        n_nxt = -$signed({1'b0, qa}) - 8'sd1;
        r_nxt = LN2_Q32 - red_rem;
      end
    end
  end

  // Taylor term divide by k: ceil(2^s/k) reciprocal, exact for 32-bit dividends
  logic [32:0] k_rc;
  logic [6:0]  k_sh;

  always_comb begin
    k_rc = 33'h1_0000_0000;
    k_sh = 7'd32;
    unique case (k_r)
      5'd2:  begin k_rc = 33'h1_0000_0000;               k_sh = 7'd33; end
      5'd3:  begin k_rc = 33'((P34 + 64'd2) / 64'd3);    k_sh = 7'd34; end
      5'd4:  begin k_rc = 33'h1_0000_0000;               k_sh = 7'd34; end
      5'd5:  begin k_rc = 33'((P35 + 64'd4) / 64'd5);    k_sh = 7'd35; end
      5'd6:  begin k_rc = 33'((P35 + 64'd5) / 64'd6);    k_sh = 7'd35; end
      5'd7:  begin k_rc = 33'((P35 + 64'd6) / 64'd7);    k_sh = 7'd35; end
      5'd8:  begin k_rc = 33'h1_0000_0000;               k_sh = 7'd35; end
      5'd9:  begin k_rc = 33'((P36 + 64'd8) / 64'd9);    k_sh = 7'd36; end
      5'd10: begin k_rc = 33'((P36 + 64'd9) / 64'd10);   k_sh = 7'd36; end
      5'd11: begin k_rc = 33'((P36 + 64'd10) / 64'd11);  k_sh = 7'd36; end
      5'd12: begin k_rc = 33'((P36 + 64'd11) / 64'd12);  k_sh = 7'd36; end
      5'd13: begin k_rc = 33'((P36 + 64'd12) / 64'd13);  k_sh = 7'd36; end
      5'd14: begin k_rc = 33'((P36 + 64'd13) / 64'd14);  k_sh = 7'd36; end
      5'd15: begin k_rc = 33'((P36 + 64'd14) / 64'd15);  k_sh = 7'd36; end
      5'd16: begin k_rc = 33'h1_0000_0000;               k_sh = 7'd36; end
      default: ;
    endcase
  end

  // multiplier operands
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  logic [32:0] e31;
  logic [32:0] term_q;

  always_comb begin
    e31   = 33'((tsum_r + 34'd1) >> 1);
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MUL_M:  begin mul_a = {2'b00, diff_r};       mul_b = {1'b0, zmag};    end
      OP_MUL_N:  begin mul_a = {3'b000, xmag};        mul_b = {1'b0, LN2_RECIP}; end
      OP_MUL_NL: begin mul_a = {26'd0, qa_r};         mul_b = {1'b0, LN2_Q32}; end
      OP_MUL_T:  begin mul_a = term_r;                mul_b = {1'b0, r_r};     end
      OP_TERM:   begin mul_a = {1'b0, prod_r[63:32]}; mul_b = k_rc;            end
      OP_MUL_P:  begin mul_a = {1'b0, spot_r};        mul_b = e31;             end
      OP_MUL_Q:  begin mul_a = {1'b0, disc_r};        mul_b = {1'b0, q_r};     end
      OP_MUL_R:  begin mul_a = {1'b0, disc_r};        mul_b = {1'b0, rem_r};   end
      default: ;
    endcase
    mul_p  = mul_a * mul_b;
    term_q = 33'(mul_p >> k_sh);
  end

  // divider operands
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = '0;
    unique case (cmd.op)
      OP_START_Q: begin
        div_start = 1'b1;
        div_dvd   = DIV_DW'(sum_r);
        div_dsr   = DIV_SW'(count_r);
      end
      OP_START_R: begin
        div_start = 1'b1;
        div_dvd   = prod_r;
        div_dsr   = DIV_SW'(count_r);
      end
      default: ;
    endcase
  end

  // terminal price from p = spot*e31 and n
  logic signed [8:0] s_v;
  logic [8:0]  l_v;
  logic [63:0] sh_v, rb_v, lim_v;
  logic [64:0] qs_v;
  logic [31:0] st;
  logic [31:0] pay;
  logic [SUM_WIDTH:0] sum_add;
  logic [63:0] t_fin;

  always_comb begin
    s_v   = 9'sd31 - 9'(n_r);
    l_v   = 9'(-s_v);
    sh_v  = prod_r >> s_v[5:0];
    rb_v  = (prod_r >> 6'(s_v[5:0] - 6'd1)) & 64'd1;
    qs_v  = {1'b0, sh_v} + {1'b0, rb_v};
    lim_v = 64'hFFFF_FFFF >> l_v[4:0];
    if (s_v > 9'sd64)       st = 32'd0;
    else if (s_v == 9'sd64) st = {31'd0, prod_r[63]};
    else if (s_v > 9'sd0)   st = (qs_v > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : qs_v[31:0];
    else if (prod_r == 64'd0) st = 32'd0;
    else if (l_v >= 9'd32)  st = 32'hFFFF_FFFF;
    else if (prod_r > lim_v) st = 32'hFFFF_FFFF;
    else                    st = 32'(prod_r << l_v[4:0]);

    if (put_r) pay = (strike_r > st) ? (strike_r - st) : 32'd0;
    else       pay = (st > strike_r) ? (st - strike_r) : 32'd0;
    sum_add = (SUM_WIDTH+1)'(sum_r) + (SUM_WIDTH+1)'(pay);
    t_fin   = t_r + div_quo + 64'h8000_0000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spot_r   <= SPOT_RST;
      strike_r <= STRIKE_RST;
      put_r    <= 1'b0;
      drift_r  <= DRIFT_RST;
      diff_r   <= DIFFUSION_RST;
      disc_r   <= DISCOUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPOT:      spot_r   <= cfg_wdata;
        REG_STRIKE:    strike_r <= cfg_wdata;
        REG_PUT:       put_r    <= cfg_wdata[0];
        REG_DRIFT:     drift_r  <= cfg_wdata;
        REG_DIFFUSION: diff_r   <= cfg_wdata[30:0];
        REG_DISCOUNT:  disc_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else if (cmd.op == OP_PRICE) begin
      sum_r   <= sum_add[SUM_WIDTH] ? '1 : sum_add[SUM_WIDTH-1:0];
      if (~&count_r) count_r <= count_r + 1'b1;
    end else if (cmd.op == OP_CLEAR) begin
      sum_r   <= '0;
      count_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        z_r    <= in_tdata;
        pair_r <= in_tuser;
        fin_r  <= in_tlast;
        path_r <= 1'b0;
      end
      OP_MUL_M, OP_MUL_NL, OP_MUL_T, OP_MUL_P, OP_MUL_Q: prod_r <= mul_p[63:0];
      OP_MUL_N: begin
        prod_r <= mul_p[63:0];
        xneg_r <= xc[30];
      end
      OP_SET_QA: qa_r <= prod_r[61:55];
      OP_MUL_R: begin
        t_r    <= prod_r;
        prod_r <= mul_p[63:0];
      end
      OP_SET_M: m_r <= 36'((prod_r + 64'd134217728) >> 28);
      OP_SET_NR: begin
        n_r    <= n_nxt;
        r_r    <= r_nxt;
        term_r <= 33'h1_0000_0000;
        tsum_r <= 34'h1_0000_0000;
        k_r    <= 5'd1;
      end
      OP_TERM: begin
        term_r <= term_q;
        tsum_r <= tsum_r + {1'b0, term_q};
        k_r    <= k_r + 5'd1;
      end
      OP_PRICE: begin
        val_r  <= st;
        kind_r <= 1'b0;
        last_r <= !(pair_r && !path_r) && !fin_r;
      end
      OP_NEXT_PATH: path_r <= 1'b1;
      OP_OPT_ZERO: begin
        val_r  <= 32'd0;
        kind_r <= 1'b1;
        last_r <= 1'b1;
      end
      OP_SET_Q: begin
        q_r   <= (|div_quo[63:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
        rem_r <= (|div_quo[63:32]) ? 32'd0 : div_rem;
      end
      OP_FINAL: begin
        val_r  <= t_fin[63:32];
        kind_r <= 1'b1;
        last_r <= 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    status.div_done   = div_done;
    status.pair       = pair_r;
    status.fin        = fin_r;
    status.path       = path_r;
    status.k_last     = (k_r == TAYLOR_TERMS);
    status.count_zero = (count_r == '0);
  end

  assign out_tdata = val_r;
  assign out_tuser = kind_r;
  assign out_tlast = last_r;

endmodule

/* hdl/aopa_ctrl.sv */
// Controller: sequences the datapath through paths, Taylor terms and the option price.
module aopa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  aopa_pkg::dp_status_t status,
  output aopa_pkg::ctrl_cmd_t  cmd
);
  import aopa_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_MZ    = 19'h00002,
    S_M     = 19'h00004,
    S_XMUL  = 19'h00008,
    S_XEST  = 19'h00010,
    S_XBACK = 19'h00020,
    S_XRED  = 19'h00040,
    S_TMUL  = 19'h00080,
    S_TDIV  = 19'h00100,
    S_PMUL  = 19'h00200,
    S_PRICE = 19'h00400,
    S_EMIT  = 19'h00800,
    S_QDIV  = 19'h01000,
    S_WQ    = 19'h02000,
    S_QMUL  = 19'h04000,
    S_RMUL  = 19'h08000,
    S_RDIV  = 19'h10000,
    S_WR    = 19'h20000,
    S_OEMIT = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = OP_NONE;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_MZ;
        end
      end
      S_MZ:    begin cmd.op = OP_MUL_M;  state_nxt = S_M;     end
      S_M:     begin cmd.op = OP_SET_M;  state_nxt = S_XMUL;  end
      S_XMUL:  begin cmd.op = OP_MUL_N;  state_nxt = S_XEST;  end
      S_XEST:  begin cmd.op = OP_SET_QA; state_nxt = S_XBACK; end
      S_XBACK: begin cmd.op = OP_MUL_NL; state_nxt = S_XRED;  end
      S_XRED:  begin cmd.op = OP_SET_NR; state_nxt = S_TMUL;  end
      S_TMUL:  begin cmd.op = OP_MUL_T;  state_nxt = S_TDIV;  end
      S_TDIV: begin
        cmd.op    = OP_TERM;
        state_nxt = status.k_last ? S_PMUL : S_TMUL;
      end
      S_PMUL:  begin cmd.op = OP_MUL_P; state_nxt = S_PRICE; end
      S_PRICE: begin cmd.op = OP_PRICE; state_nxt = S_EMIT;  end
      S_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (status.pair && !status.path) begin
            cmd.op    = OP_NEXT_PATH;
            state_nxt = S_XMUL;
          end else if (status.fin) begin
            if (status.count_zero) begin
              cmd.op    = OP_OPT_ZERO;
              state_nxt = S_OEMIT;
            end else begin
              state_nxt = S_QDIV;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_QDIV: begin cmd.op = OP_START_Q; state_nxt = S_WQ; end
      S_WQ: begin
        if (status.div_done) begin
          cmd.op    = OP_SET_Q;
          state_nxt = S_QMUL;
        end
      end
      S_QMUL: begin cmd.op = OP_MUL_Q;   state_nxt = S_RMUL; end
      S_RMUL: begin cmd.op = OP_MUL_R;   state_nxt = S_RDIV; end
      S_RDIV: begin cmd.op = OP_START_R; state_nxt = S_WR;   end
      S_WR: begin
        if (status.div_done) begin
          cmd.op    = OP_FINAL;
          state_nxt = S_OEMIT;
        end
      end
      S_OEMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.op    = OP_CLEAR;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_MZ))
    else $error("accepted item did not start the path sequence");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while a result is pending");

  a_option_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OEMIT && out_tready) |=> (state_r == S_IDLE))
    else $error("option price transfer did not end the item");
`endif

endmodule

/* hdl/antithetic_option_payoff_accumulator.sv */
// Top level: Monte Carlo European option pricer with antithetic paths.
// Sequence: the first terminal price follows the input transfer (range reduction by
// reciprocal multiply, 16 Taylor terms); in pair mode the antithetic price follows it.
// Final draw: the option price follows the last price transfer and two divides.
// Throughput: one item at a time; the next item is taken once the last result transfers.
// Reset (rst_n low, synchronous) restores register defaults and clears sum and count.
module antithetic_option_payoff_accumulator #(
  parameter int SUM_WIDTH   = aopa_pkg::SUM_WIDTH_DEF,
  parameter int COUNT_WIDTH = aopa_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [aopa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // normal_draw
  input  logic                          in_tuser,   // pair_mode
  input  logic                          in_tlast,   // final_draw
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // result_value
  output logic                          out_tuser,  // result_kind
  output logic                          out_tlast   // run_last
);
  import aopa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  aopa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  aopa_datapath #(
    .SUM_WIDTH  (SUM_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .in_tlast (in_tlast),
    .cmd      (cmd),
    .status   (status),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

endmodule
